@@ hdl/pps_pkg.sv @@
// Shared constants and types for the preemptive priority scheduler.
package pps_pkg;

  localparam int unsigned MAX_PROCS = 16;
  localparam int unsigned SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // Best candidate seen so far, handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [7:0]        prio;
    logic [15:0]       arrival;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       id;
    logic [15:0]       burst;
    logic [15:0]       rem;
  } cand_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [15:0]       wr_id;
    logic [15:0]       wr_burst;
    logic [15:0]       wr_arrival;
    logic [7:0]        wr_prio;
    logic              dec_en;
    logic [SLOT_W-1:0] dec_slot;
    logic [15:0]       now;
    logic [CNT_W-1:0]  loaded;
  } cell_ctl_t;

endpackage

@@ hdl/pps_cell.sv @@
// One process table slot that keeps the better of its own entry and its neighbor's candidate.
module pps_cell
  import pps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] slot_i,
  input  cell_ctl_t         ctl_i,
  input  cand_t             prev_i,
  output cand_t             next_o
);

  logic [15:0] id_q;
  logic [15:0] burst_q;
  logic [15:0] arr_q;
  logic [7:0]  prio_q;
  logic [15:0] rem_q;
  logic        eligible;
  logic        wins;
  cand_t       next_d;
  cand_t       next_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && (ctl_i.wr_slot == slot_i)) begin
      id_q    <= ctl_i.wr_id;
      burst_q <= ctl_i.wr_burst;
      arr_q   <= ctl_i.wr_arrival;
      prio_q  <= ctl_i.wr_prio;
      rem_q   <= ctl_i.wr_burst;
    end else if (ctl_i.dec_en && (ctl_i.dec_slot == slot_i)) begin
      rem_q <= rem_q - 16'd1;
    end
  end

  // Ties keep the incoming candidate, which always comes from a lower slot.
  always_comb begin
    eligible = (CNT_W'(slot_i) < ctl_i.loaded) && (rem_q != 16'd0) &&
               (arr_q <= ctl_i.now);
    wins = !prev_i.valid || (prio_q < prev_i.prio) ||
           ((prio_q == prev_i.prio) && (arr_q < prev_i.arrival));
    if (eligible && wins) begin
      next_d.valid   = 1'b1;
      next_d.prio    = prio_q;
      next_d.arrival = arr_q;
      next_d.slot    = slot_i;
      next_d.id      = id_q;
      next_d.burst   = burst_q;
      next_d.rem     = rem_q;
    end else begin
      next_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
    end else begin
      next_q <= next_d;
    end
  end

  assign next_o = next_q;

endmodule

@@ hdl/preemptive_priority_scheduler.sv @@
// Preemptive priority scheduler: a chain of table cells picks the process to run on each tick.
// A load request returns nothing; the next request can be accepted right after it.
// A tick request returns one result: the best candidate walks the registered cell chain one
// slot per cycle, then the update state updates the winner and registers the result. No
// new request is accepted until the tick leaves the update state, which stalls while an
// earlier result still waits at the output. Reset clears the time, the load and done
// counts and the output valid; table contents stay undefined until loaded.
module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // proc_id[15:0], burst_len[31:16], arrive_at[47:32], prio_level[55:48]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // mode[0]
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // running_id[15:0], idle[16], finished[17], finish_time[33:18], turnaround[49:34],
  // wait_time[65:50], all_done[66], zero fill[71:67]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0]  loaded_q, loaded_d;
  logic [CNT_W-1:0]  done_q, done_d;
  logic [15:0]       now_q, now_d;
  logic              m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  cand_t     chain [MAX_PROCS+1];
  cell_ctl_t ctl;
  cand_t     best;

  logic        in_fire;
  logic        out_free;
  logic        do_load;
  logic        do_update;
  logic        finished;
  logic [15:0] fin;
  logic [15:0] tat;
  logic [15:0] wt;
  logic [CNT_W-1:0] done_next;

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    pps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .slot_i (SLOT_W'(i)),
      .ctl_i  (ctl),
      .prev_i (chain[i]),
      .next_o (chain[i+1])
    );
  end

  assign best     = chain[MAX_PROCS];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (in_fire && (s_axis_tuser_i == MODE_TICK)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + SLOT_W'(1);
        if (scan_q == SLOT_W'(MAX_PROCS - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    do_load   = in_fire && (s_axis_tuser_i == MODE_LOAD) &&
                (loaded_q < CNT_W'(MAX_PROCS));
    do_update = (state_q == ST_UPDATE) && out_free;

    finished  = best.valid && (best.rem == 16'd1);
    fin       = now_q + 16'd1;
    tat       = fin - best.arrival;
    wt        = tat - best.burst;
    done_next = done_q + (finished ? CNT_W'(1) : CNT_W'(0));

    ctl.wr_en      = do_load;
    ctl.wr_slot    = loaded_q[SLOT_W-1:0];
    ctl.wr_id      = s_axis_tdata_i[15:0];
    ctl.wr_burst   = s_axis_tdata_i[31:16];
    ctl.wr_arrival = s_axis_tdata_i[47:32];
    ctl.wr_prio    = s_axis_tdata_i[55:48];
    ctl.dec_en     = do_update && best.valid;
    ctl.dec_slot   = best.slot;
    ctl.now        = now_q;
    ctl.loaded     = loaded_q;

    loaded_d  = loaded_q;
    done_d    = done_q;
    now_d     = now_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;

    if (do_load) begin
      loaded_d = loaded_q + CNT_W'(1);
      if (s_axis_tdata_i[31:16] == 16'd0) begin
        done_d = done_q + CNT_W'(1);
      end
    end

    if (do_update) begin
      done_d    = done_next;
      now_d     = fin;
      m_valid_d = 1'b1;
      m_data_d  = '0;
      m_data_d[15:0]  = best.valid ? best.id : 16'd0;
      m_data_d[16]    = !best.valid;
      m_data_d[17]    = finished;
      m_data_d[33:18] = finished ? fin : 16'd0;
      m_data_d[49:34] = finished ? tat : 16'd0;
      m_data_d[65:50] = finished ? wt : 16'd0;
      m_data_d[66]    = (done_next == loaded_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      loaded_q  <= '0;
      done_q    <= '0;
      now_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      loaded_q  <= loaded_d;
      done_q    <= done_d;
      now_q     <= now_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  // Completed processes can never outnumber loaded ones.
  a_done_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= loaded_q)
    else $error("done count exceeds loaded count");

  // A new result only appears after the update cycle of a tick.
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_UPDATE))
    else $error("result raised outside the update cycle");

  // An idle tick never reports a completion or a running process.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[16]) |-> (!m_data_q[17] && (m_data_q[15:0] == 16'd0)))
    else $error("idle tick reports a process");
`endif

endmodule

@@ verif/preemptive_priority_scheduler_tb.sv @@
// Self-checking testbench for the preemptive priority scheduler stream block.
module preemptive_priority_scheduler_tb;
  import pps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_PROCS + 8;

  typedef struct packed {
    logic [15:0] running_id;
    logic        idle;
    logic        finished;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
    logic [15:0] wait_time;
    logic        all_done;
  } report_t;

  typedef enum int {
    RX_OPEN,
    RX_CHOPPY,
    RX_THROTTLED
  } rx_mode_e;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data = '0;
  logic                  s_user = MODE_LOAD;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;

  // Scheduler state as the testbench sees it.
  logic [15:0] tbl_id      [MAX_PROCS];
  logic [15:0] tbl_burst   [MAX_PROCS];
  logic [15:0] tbl_arrival [MAX_PROCS];
  logic [7:0]  tbl_prio    [MAX_PROCS];
  logic [15:0] tbl_left    [MAX_PROCS];
  int          n_loaded = 0;
  int          n_done = 0;
  logic [15:0] clock_now = '0;

  report_t  expected_reports[$];
  report_t  pending_report;
  int       error_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       stall_left = 0;
  rx_mode_e stall_kind = RX_OPEN;

  preemptive_priority_scheduler dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("preemptive_priority_scheduler test failed");
      $finish;
    end
  end

  // Applies one accepted request to the scheduler state and queues the report a tick yields.
  task automatic predict_schedule(input logic mode, input logic [15:0] pid,
                                  input logic [15:0] blen, input logic [15:0] arr,
                                  input logic [7:0] prio);
    report_t rep;
    int      pick;
    bit      found;
    pick = 0;
    found = 1'b0;
    rep = '0;
    if (mode == MODE_LOAD) begin
      if (n_loaded < MAX_PROCS) begin
        tbl_id[n_loaded] = pid;
        tbl_burst[n_loaded] = blen;
        tbl_arrival[n_loaded] = arr;
        tbl_prio[n_loaded] = prio;
        tbl_left[n_loaded] = blen;
        if (blen == 16'd0) n_done++;
        n_loaded++;
      end
    end else begin
      // Strict compares leave ties with the lower slot, which is scanned first.
      for (int i = 0; i < n_loaded; i++) begin
        if (tbl_left[i] == 16'd0 || tbl_arrival[i] > clock_now) continue;
        if (!found || tbl_prio[i] < tbl_prio[pick] ||
            (tbl_prio[i] == tbl_prio[pick] && tbl_arrival[i] < tbl_arrival[pick])) begin
          pick = i;
          found = 1'b1;
        end
      end
      clock_now = clock_now + 16'd1;
      rep.idle = !found;
      if (found) begin
        rep.running_id = tbl_id[pick];
        tbl_left[pick] = tbl_left[pick] - 16'd1;
        if (tbl_left[pick] == 16'd0) begin
          n_done++;
          rep.finished = 1'b1;
          rep.finish_time = clock_now;
          rep.turnaround = clock_now - tbl_arrival[pick];
          rep.wait_time = rep.turnaround - tbl_burst[pick];
        end
      end
      rep.all_done = (n_done == n_loaded);
      expected_reports.push_back(rep);
    end
  endtask

  // Offers one request, holding it until accepted; starts and ends at a falling edge.
  task automatic push_request(input logic mode, input logic [15:0] pid,
                              input logic [15:0] blen, input logic [15:0] arr,
                              input logic [7:0] prio);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user <= mode;
    s_data <= {prio, arr, blen, pid};
    do @(posedge clk); while (!s_ready);
    predict_schedule(mode, pid, blen, arr, prio);
    @(negedge clk);
  endtask

  task automatic send_tick();
    push_request(MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic load_random_entry();
    logic [15:0] lo;
    logic [15:0] blen;
    logic [7:0]  prio;
    lo = (clock_now > 16'd30) ? clock_now - 16'd30 : 16'd0;
    blen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 3)) : 16'($urandom_range(1, 120));
    // A narrow priority band makes ties on priority and arrival common.
    prio = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    push_request(MODE_LOAD, 16'($urandom), blen, lo + 16'($urandom_range(0, 70)), prio);
  endtask

  task automatic test_nothing_loaded();
    repeat (2) send_tick();
  endtask

  // Extreme ids and priorities, a zero burst, future arrivals, both tie breaks and preemption.
  task automatic test_directed_mix();
    push_request(MODE_LOAD, 16'hFFFF, 16'd3, 16'd0, 8'hFF);
    push_request(MODE_LOAD, 16'h0000, 16'd0, 16'd0, 8'h00);
    push_request(MODE_LOAD, 16'h1234, 16'd2, clock_now + 16'd2, 8'd10);
    push_request(MODE_LOAD, 16'h2222, 16'd2, clock_now + 16'd2, 8'd10);
    repeat (4) send_tick();
    push_request(MODE_LOAD, 16'h4321, 16'd1, 16'd0, 8'd10);
    repeat (5) send_tick();
  endtask

  task automatic test_random_mix();
    int spare;
    spare = MAX_PROCS - n_loaded - 2;
    for (int k = 0; k < 900; k++) begin
      if (spare > 0 && $urandom_range(0, 999) < 12) begin
        load_random_entry();
        spare--;
      end else begin
        send_tick();
      end
    end
  endtask

  task automatic test_table_full();
    while (n_loaded < MAX_PROCS) load_random_entry();
    push_request(MODE_LOAD, 16'hBEEF, 16'd5, 16'd0, 8'h00);
    repeat (6) send_tick();
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = rx_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_kind)
      RX_OPEN: m_ready <= 1'b1;
      RX_CHOPPY: m_ready <= ($urandom_range(0, 1) == 1);
      default: m_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      if (expected_reports.size() == 0) begin
        $error("report with no tick request pending: tdata %h", m_data);
        error_count++;
      end else begin
        pending_report = expected_reports.pop_front();
        compare_field("running_id", pending_report.running_id, m_data[15:0]);
        compare_field("idle", 16'(pending_report.idle), 16'(m_data[16]));
        compare_field("finished", 16'(pending_report.finished), 16'(m_data[17]));
        compare_field("finish_time", pending_report.finish_time, m_data[33:18]);
        compare_field("turnaround", pending_report.turnaround, m_data[49:34]);
        compare_field("wait_time", pending_report.wait_time, m_data[65:50]);
        compare_field("all_done", 16'(pending_report.all_done), 16'(m_data[66]));
        compare_field("zero fill", 16'd0, 16'(m_data[71:67]));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_nothing_loaded();
    test_directed_mix();
    test_random_mix();
    test_table_full();
    s_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("preemptive_priority_scheduler test passed");
    end else begin
      $display("preemptive_priority_scheduler test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pps_pkg.sv
hdl/pps_cell.sv
hdl/preemptive_priority_scheduler.sv
verif/preemptive_priority_scheduler_tb.sv
